FILE: rtl/lscn_pkg.sv
// lscn_pkg: shared constants, field widths and controller command type
// for the line sensor calibrate and normalize unit
// no dependencies
package lscn_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 10;
    localparam int REG_W    = 10;
    localparam int PAT_W    = 8;
    localparam int DIV_CNT_W = $clog2(REG_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;

    localparam logic [REG_W-1:0] RESOLUTION_RST = 10'd100;
    localparam logic [REG_W-1:0] THRESHOLD_RST  = 10'd60;

    typedef struct packed {
        logic capture;
        logic update;
        logic mul;
        logic div_step;
        logic finish;
    } cmd_t;

endpackage

FILE: rtl/line_sensor_calibrate_normalize_unit.sv
// line_sensor_calibrate_normalize_unit: top level, min/max calibration
// and normalization of line sensor samples with indicator pattern
// depends on lscn_pkg, lscn_ctrl, lscn_dp
//
//  channel   signals                                    handshake
//  input     channel, sample                            in_valid / in_ready
//  output    out_channel, norm_value, span_zero,        out_valid / out_ready
//            indicator_bits
//  config    cfg_addr, cfg_wdata                        cfg_we, no wait
//
// a new beat is accepted only once the previous one has gone through the store update,
// the multiply, the 10-step shift-subtract divider and the final step
// the output register holds a result while the next beat is accepted
// out_ready low only holds the final step until the output register frees
// reset loads all stores at once; no clearing pass
module line_sensor_calibrate_normalize_unit
#(
    parameter int CHANNELS    = lscn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lscn_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lscn_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lscn_pkg::REG_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lscn_pkg::CH_W-1:0]        channel,
    input  logic [lscn_pkg::SAMPLE_W-1:0]    sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lscn_pkg::CH_W-1:0]        out_channel,
    output logic [lscn_pkg::REG_W-1:0]       norm_value,
    output logic                             span_zero,
    output logic [lscn_pkg::PAT_W-1:0]       indicator_bits
);

    lscn_pkg::cmd_t cmd;

    lscn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lscn_dp
    #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .channel        (channel),
        .sample         (sample),
        .out_channel    (out_channel),
        .norm_value     (norm_value),
        .span_zero      (span_zero),
        .indicator_bits (indicator_bits)
    );

endmodule

FILE: rtl/lscn_ctrl.sv
// lscn_ctrl: sequencer for one sample beat, drives datapath commands
// and owns the input ready and output valid handshake
// depends on lscn_pkg
module lscn_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output lscn_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_FIN    = 5'b10000
    } state_t;

    localparam logic [lscn_pkg::DIV_CNT_W-1:0] DIV_LAST =
        lscn_pkg::DIV_CNT_W'(lscn_pkg::REG_W - 1);

    state_t state_reg;
    state_t state_next;
    logic [lscn_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [lscn_pkg::DIV_CNT_W-1:0] cnt_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.capture  = 1'b0;
        cmd.update   = 1'b0;
        cmd.mul      = 1'b0;
        cmd.div_step = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // divide phase always runs the full quotient width
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == DIV_LAST) |=> (state_reg == S_FIN))
        else $error("divide phase length wrong");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    // an accepted beat starts the store update next cycle
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_UPDATE))
        else $error("accepted beat not started");

endmodule

FILE: rtl/lscn_dp.sv
// lscn_dp: datapath with per-channel peak/floor stores, multiplier,
// shift-subtract divider, indicator pattern, config and output registers
// depends on lscn_pkg
module lscn_dp
#(
    parameter int CHANNELS    = lscn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lscn_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lscn_pkg::cmd_t                   cmd,
    input  logic                             cfg_we,
    input  logic [lscn_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lscn_pkg::REG_W-1:0]       cfg_wdata,
    input  logic [lscn_pkg::CH_W-1:0]        channel,
    input  logic [lscn_pkg::SAMPLE_W-1:0]    sample,
    output logic [lscn_pkg::CH_W-1:0]        out_channel,
    output logic [lscn_pkg::REG_W-1:0]       norm_value,
    output logic                             span_zero,
    output logic [lscn_pkg::PAT_W-1:0]       indicator_bits
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QB    = lscn_pkg::REG_W;
    localparam int NUM_W = QB + SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] peak_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] floor_reg [CHANNELS];

    logic [lscn_pkg::REG_W-1:0] resolution_reg;
    logic [lscn_pkg::REG_W-1:0] threshold_reg;
    logic [lscn_pkg::PAT_W-1:0] pattern_reg;
    logic [lscn_pkg::PAT_W-1:0] pattern_next;

    logic [lscn_pkg::CH_W-1:0] ch_reg;
    logic [SAMPLE_BITS-1:0]    smp_reg;
    logic                      chok_reg;
    logic [SAMPLE_BITS-1:0]    span_reg;
    logic [SAMPLE_BITS-1:0]    diff_reg;
    logic [SAMPLE_BITS-1:0]    rem_reg;
    logic [QB-1:0]             work_reg;

    logic [lscn_pkg::CH_W-1:0]  out_channel_reg;
    logic [lscn_pkg::REG_W-1:0] norm_reg;
    logic                       zero_reg;
    logic [lscn_pkg::PAT_W-1:0] out_pattern_reg;

    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] peak_cur;
    logic [SAMPLE_BITS-1:0] floor_cur;
    logic [SAMPLE_BITS-1:0] peak_new;
    logic [SAMPLE_BITS-1:0] floor_new;
    logic [NUM_W-1:0]       prod;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   trial;
    logic                   ge;
    logic                   zero_fin;
    logic [QB-1:0]          norm_fin;

    assign idx       = IDX_W'(ch_reg);
    assign peak_cur  = peak_reg[idx];
    assign floor_cur = floor_reg[idx];
    assign peak_new  = (peak_cur < smp_reg) ? smp_reg : peak_cur;
    assign floor_new = (floor_cur > smp_reg) ? smp_reg : floor_cur;

    assign prod = NUM_W'(resolution_reg) * NUM_W'(diff_reg);

    // one restoring quotient bit per step
    assign shifted = {rem_reg, work_reg[QB-1]};
    assign trial   = shifted - {1'b0, span_reg};
    assign ge      = (shifted >= {1'b0, span_reg});

    assign zero_fin = chok_reg && (span_reg == '0);
    assign norm_fin = (chok_reg && (span_reg != '0)) ? work_reg : '0;

    always_comb
    begin
        pattern_next = pattern_reg;
        if (chok_reg)
        begin
            pattern_next[ch_reg] = (norm_fin < threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= lscn_pkg::RESOLUTION_RST;
            threshold_reg  <= lscn_pkg::THRESHOLD_RST;
            pattern_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                peak_reg[i]  <= '0;
                floor_reg[i] <= FULL_SCALE;
            end
        end
        else
        begin
            if (cfg_we && cfg_addr == lscn_pkg::REG_RESOLUTION)
            begin
                resolution_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == lscn_pkg::REG_THRESHOLD)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (cmd.update && chok_reg)
            begin
                peak_reg[idx]  <= peak_new;
                floor_reg[idx] <= floor_new;
            end
            if (cmd.finish)
            begin
                pattern_reg <= pattern_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel;
            smp_reg  <= SAMPLE_BITS'(sample);
            chok_reg <= (int'(channel) < CHANNELS);
        end
        if (cmd.update)
        begin
            span_reg <= peak_new - floor_new;
            diff_reg <= peak_new - smp_reg;
        end
        if (cmd.mul)
        begin
            rem_reg  <= prod[NUM_W-1:QB];
            work_reg <= prod[QB-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            work_reg <= {work_reg[QB-2:0], ge};
        end
        if (cmd.finish)
        begin
            out_channel_reg <= ch_reg;
            norm_reg        <= norm_fin;
            zero_reg        <= zero_fin;
            out_pattern_reg <= pattern_next;
        end
    end

    assign out_channel    = out_channel_reg;
    assign norm_value     = norm_reg;
    assign span_zero      = zero_reg;
    assign indicator_bits = out_pattern_reg;

    // quotient never exceeds the resolution setting, the full scale of the normalized output
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (norm_fin <= resolution_reg))
        else $error("normalized value above resolution");

endmodule
